### rtl/core/lmsaf_pkg.sv
// Shared types, constants and codes for the LMS adaptive FIR filter.
// Depends on nothing; every other file of the block imports it.
package lmsaf_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned TAP_W       = 24;
    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned TAP_INDEX_W = 5;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned SKIP_W      = 16;
    localparam int unsigned DECIM_W     = 9;
    localparam int unsigned PHASE_W     = 8;
    localparam int unsigned SKIP_CNT_W  = 17;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [STEP_W-1:0]     STEP_RESET  = 16'd328;
    localparam logic [SKIP_W-1:0]     SKIP_RESET  = 16'd0;
    localparam logic [DECIM_W-1:0]    DECIM_RESET = 9'd1;
    localparam logic [DECIM_W-1:0]    DECIM_MAX   = 9'd256;
    localparam logic [STEP_W-1:0]     STEP_MAX    = 16'h8000;
    localparam logic [SKIP_CNT_W-1:0] SKIP_CNT_MAX = 17'h1FFFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE     = 2'd0,
        OP_WRITE_TAP  = 2'd1,
        OP_CLEAR_TAPS = 2'd2
    } opcode_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STEP_SIZE      = 3'd0,
        CFG_SKIP_COUNT     = 3'd1,
        CFG_DECIM_FACTOR   = 3'd2,
        CFG_ADAPT_ENABLE   = 3'd3,
        CFG_BYPASS_ENABLE  = 3'd4,
        CFG_ERROR_FROM_REF = 3'd5
    } cfg_reg_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_ROUND,
        S_ERROR,
        S_SCALE,
        S_UPDATE,
        S_OUTPUT
    } seq_state_e;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic signed [SAMPLE_W-1:0] desired_sample;
        logic signed [SAMPLE_W-1:0] input_sample;
        logic signed [SAMPLE_W-1:0] filtered_sample;
        logic [TAP_INDEX_W-1:0]     tap_index;
        logic signed [TAP_W-1:0]    tap_value;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filter_out;
        logic signed [SAMPLE_W-1:0] error_sample;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_word_t;

    // Control of the cell ring.
    typedef struct packed {
        logic shift_window;
        logic shift_tap;
        logic load_sample;
        logic apply_update;
        logic write_tap;
        logic clear_taps;
    } ring_ctrl_t;

    // Control of the shared head arithmetic.
    typedef struct packed {
        logic sample_load;
        logic bypass_load;
        logic acc_step;
        logic y_load;
        logic e_load;
        logic mue_load;
    } dp_ctrl_t;

endpackage

### rtl/core/lmsaf_if.sv
// Valid/ready channel interfaces for item, result and configuration words.
// Depends on lmsaf_pkg for the payload types.
interface lmsaf_item_if import lmsaf_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lmsaf_result_if import lmsaf_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lmsaf_cfg_if import lmsaf_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/lmsaf_tap_cell.sv
// One cell of the filter ring: window sample, regressor sample and tap.
// Depends on lmsaf_pkg.
module lmsaf_tap_cell import lmsaf_pkg::*; #(
    parameter int CELL_INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ring_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] x_in,
    input  logic signed [SAMPLE_W-1:0] r_in,
    input  logic signed [TAP_W-1:0]    tap_in,
    input  logic [TAP_INDEX_W-1:0]     tap_index,
    input  logic signed [TAP_W-1:0]    tap_value,
    output logic signed [SAMPLE_W-1:0] x_q,
    output logic signed [SAMPLE_W-1:0] r_q,
    output logic signed [TAP_W-1:0]    tap_q
);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] r_reg;
    logic signed [TAP_W-1:0]    tap_reg;
    logic                       hit;

    assign hit = (int'(tap_index) == CELL_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            r_reg   <= '0;
            tap_reg <= '0;
        end
        else
        begin
            if (ctrl.shift_window)
            begin
                x_reg <= x_in;
                r_reg <= r_in;
            end
            priority if (ctrl.clear_taps)
            begin
                tap_reg <= '0;
            end
            else if (ctrl.write_tap && hit)
            begin
                tap_reg <= tap_value;
            end
            else if (ctrl.shift_tap)
            begin
                tap_reg <= tap_in;
            end
        end
    end

    assign x_q   = x_reg;
    assign r_q   = r_reg;
    assign tap_q = tap_reg;

endmodule

### rtl/core/lmsaf_datapath.sv
// Shared head arithmetic: dot-product accumulator, rounding, error,
// step scaling and the per-tap update. Depends on lmsaf_pkg.
module lmsaf_datapath import lmsaf_pkg::*; #(
    parameter int unsigned TAP_COUNT = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_ctrl_t                   ctrl,
    input  logic signed [SAMPLE_W-1:0] desired_sample,
    input  logic signed [SAMPLE_W-1:0] input_sample,
    input  logic [STEP_W-1:0]          step_size,
    input  logic                       error_from_reference,
    input  logic signed [TAP_W-1:0]    tap_head,
    input  logic signed [SAMPLE_W-1:0] x_head,
    input  logic signed [SAMPLE_W-1:0] r_head,
    output logic signed [TAP_W-1:0]    tap_updated,
    output logic signed [SAMPLE_W-1:0] filter_out,
    output logic signed [SAMPLE_W-1:0] error_sample
);

    localparam int unsigned PROD_W = TAP_W + SAMPLE_W;
    localparam int unsigned ACC_W  = PROD_W + $clog2(TAP_COUNT);
    localparam int unsigned MUE_W  = 32;
    localparam int unsigned UPD_W  = MUE_W + SAMPLE_W;
    localparam int unsigned DELTA_W = UPD_W - 25;

    localparam logic signed [ACC_W-1:0] ROUND_Y = ACC_W'(signed'(32'sh0008_0000));
    localparam logic signed [ACC_W-1:0] Y_MAX   = ACC_W'(signed'(32'sd32767));
    localparam logic signed [ACC_W-1:0] Y_MIN   = ACC_W'(signed'(-32'sd32768));
    localparam logic signed [UPD_W-1:0] ROUND_U = UPD_W'(signed'(32'sh0100_0000));

    logic signed [PROD_W-1:0]   mac_prod;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    y_round;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [SAMPLE_W:0]   e_diff;
    logic signed [SAMPLE_W-1:0] e_next;
    logic [STEP_W-1:0]          mu_clamped;
    logic signed [MUE_W-1:0]    mue_prod;
    logic signed [MUE_W-1:0]    mue_reg;
    logic signed [UPD_W-1:0]    upd_prod;
    logic signed [UPD_W-1:0]    upd_round;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [TAP_W:0]      tap_sum;
    logic signed [SAMPLE_W-1:0] desired_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [SAMPLE_W-1:0] e_reg;

    assign mac_prod = tap_head * x_head;

    // Q10.35 sum to Q1.15, round half up, saturate.
    assign y_round = (acc_reg + ROUND_Y) >>> 20;

    always_comb
    begin
        priority if (y_round > Y_MAX)
        begin
            y_sat = 16'sh7FFF;
        end
        else if (y_round < Y_MIN)
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = y_round[SAMPLE_W-1:0];
        end
    end

    assign e_diff = (SAMPLE_W+1)'(desired_reg) - (SAMPLE_W+1)'(y_reg);

    always_comb
    begin
        priority if (!error_from_reference)
        begin
            e_next = desired_reg;
        end
        else if (e_diff[SAMPLE_W] != e_diff[SAMPLE_W-1])
        begin
            e_next = e_diff[SAMPLE_W] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            e_next = e_diff[SAMPLE_W-1:0];
        end
    end

    assign mu_clamped = (step_size > STEP_MAX) ? STEP_MAX : step_size;
    assign mue_prod   = $signed({1'b0, mu_clamped}) * e_reg;

    // Q3.45 update rounded half up to Q3.20.
    assign upd_prod  = mue_reg * r_head;
    assign upd_round = upd_prod + ROUND_U;
    assign delta     = upd_round[UPD_W-1:25];
    assign tap_sum   = (TAP_W+1)'(tap_head) + (TAP_W+1)'(delta);

    always_comb
    begin
        if (tap_sum[TAP_W] != tap_sum[TAP_W-1])
        begin
            tap_updated = tap_sum[TAP_W] ? 24'sh800000 : 24'sh7FFFFF;
        end
        else
        begin
            tap_updated = tap_sum[TAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.sample_load)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_step)
        begin
            acc_reg <= acc_reg + ACC_W'(mac_prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sample_load)
        begin
            desired_reg <= desired_sample;
        end
        if (ctrl.bypass_load)
        begin
            y_reg <= input_sample;
        end
        else if (ctrl.y_load)
        begin
            y_reg <= y_sat;
        end
        if (ctrl.bypass_load)
        begin
            e_reg <= '0;
        end
        else if (ctrl.e_load)
        begin
            e_reg <= e_next;
        end
        if (ctrl.mue_load)
        begin
            mue_reg <= mue_prod;
        end
    end

    assign filter_out   = y_reg;
    assign error_sample = e_reg;

endmodule

### rtl/core/lmsaf_seq.sv
// Sequencer: accepts items, runs the dot-product and update passes over the
// cell ring, tracks decimation phase and the skip counter. Depends on lmsaf_pkg.
module lmsaf_seq import lmsaf_pkg::*; #(
    parameter int unsigned TAP_COUNT = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic [OPCODE_W-1:0]   item_opcode,
    input  logic [SKIP_W-1:0]     skip_count,
    input  logic [DECIM_W-1:0]    decim_factor,
    input  logic                  adapt_enable,
    input  logic                  bypass_enable,
    input  logic                  out_free,
    output logic                  item_ready,
    output logic                  out_load,
    output ring_ctrl_t            ring_ctrl,
    output dp_ctrl_t              dp_ctrl
);

    localparam int unsigned CNT_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAP_COUNT - 1);

    seq_state_e              state_reg;
    seq_state_e              state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [PHASE_W-1:0]      phase_reg;
    logic [PHASE_W-1:0]      phase_next;
    logic [SKIP_CNT_W-1:0]   skip_cnt_reg;
    logic [SKIP_CNT_W-1:0]   skip_cnt_next;
    logic [DECIM_W-1:0]      decim_eff;
    logic [DECIM_W-1:0]      phase_inc;
    logic                    emit;
    logic                    sample_take;
    logic                    cnt_last;
    logic                    adapt_go;
    logic                    in_pass;

    assign emit      = (phase_reg == '0);
    assign cnt_last  = (cnt_reg == CNT_LAST);
    assign in_pass   = (state_reg == S_MAC) || (state_reg == S_UPDATE);
    assign sample_take = (state_reg == S_IDLE) && item_valid && (item_opcode == OP_SAMPLE);

    always_comb
    begin
        priority if (decim_factor == '0)
        begin
            decim_eff = DECIM_W'(1);
        end
        else if (decim_factor > DECIM_MAX)
        begin
            decim_eff = DECIM_MAX;
        end
        else
        begin
            decim_eff = decim_factor;
        end
    end

    assign phase_inc  = DECIM_W'(phase_reg) + DECIM_W'(1);
    assign phase_next = (phase_inc >= decim_eff) ? '0 : phase_inc[PHASE_W-1:0];

    assign adapt_go = adapt_enable &&
                      ((skip_count == '0) ||
                       (skip_cnt_reg >= (SKIP_CNT_W'(skip_count) + SKIP_CNT_W'(1))));

    always_comb
    begin
        priority if (adapt_go)
        begin
            skip_cnt_next = '0;
        end
        else if (skip_cnt_reg != SKIP_CNT_MAX)
        begin
            skip_cnt_next = skip_cnt_reg + SKIP_CNT_W'(1);
        end
        else
        begin
            skip_cnt_next = skip_cnt_reg;
        end
    end

    assign cnt_next = (in_pass && !cnt_last) ? cnt_reg + CNT_W'(1) : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_take && emit)
                begin
                    state_next = bypass_enable ? S_OUTPUT : S_MAC;
                end
            end
            S_MAC:
            begin
                if (cnt_last)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                state_next = S_ERROR;
            end
            S_ERROR:
            begin
                state_next = adapt_go ? S_SCALE : S_OUTPUT;
            end
            S_SCALE:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (cnt_last)
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        item_ready             = (state_reg == S_IDLE);
        out_load               = (state_reg == S_OUTPUT) && out_free;
        ring_ctrl.shift_window = sample_take || in_pass;
        ring_ctrl.shift_tap    = in_pass;
        ring_ctrl.load_sample  = sample_take;
        ring_ctrl.apply_update = (state_reg == S_UPDATE);
        ring_ctrl.write_tap    = (state_reg == S_IDLE) && item_valid &&
                                 (item_opcode == OP_WRITE_TAP);
        ring_ctrl.clear_taps   = (state_reg == S_IDLE) && item_valid &&
                                 (item_opcode == OP_CLEAR_TAPS);
        dp_ctrl.sample_load    = sample_take;
        dp_ctrl.bypass_load    = sample_take && emit && bypass_enable;
        dp_ctrl.acc_step       = (state_reg == S_MAC);
        dp_ctrl.y_load         = (state_reg == S_ROUND);
        dp_ctrl.e_load         = (state_reg == S_ERROR);
        dp_ctrl.mue_load       = (state_reg == S_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            phase_reg    <= '0;
            skip_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (sample_take)
            begin
                phase_reg <= phase_next;
            end
            if (state_reg == S_ERROR)
            begin
                skip_cnt_reg <= skip_cnt_next;
            end
        end
    end

endmodule

### rtl/core/lms_adaptive_fir_filter_unit.sv
// LMS adaptive FIR filter, top level: config registers, cell ring,
// sequencer, head arithmetic and result register.
// Depends on lmsaf_pkg, lmsaf_if, lmsaf_tap_cell, lmsaf_datapath, lmsaf_seq.
//
// Channels: item (sink) carries one sample, tap write or tap clear word;
// result (source) carries filter_out and error_sample; cfg (sink) writes one
// register per word and is always ready. Config must be written only while idle;
// the block itself does not enforce this. Tap write, tap clear and samples that
// produce no result leave the sequencer idle and ready for the next item. A
// result sample makes a dot-product pass over the ring through the head
// multiplier, then rounding and error, and when the taps adapt a scaling step
// and an update pass through the same head, before the result is registered.
// Bypass samples go from idle straight to the output state.
// The result register holds one word; the next item is accepted while it
// waits, and the sequencer stalls only when a new result meets a full
// result register. Reset clears windows, taps, counters and config to
// their defaults; no clearing pass is needed.
module lms_adaptive_fir_filter_unit import lmsaf_pkg::*; #(
    parameter int unsigned TAP_COUNT = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    lmsaf_item_if.sink    item,
    lmsaf_result_if.source result,
    lmsaf_cfg_if.sink     cfg
);

    logic [STEP_W-1:0]  step_size_reg;
    logic [SKIP_W-1:0]  skip_count_reg;
    logic [DECIM_W-1:0] decim_factor_reg;
    logic               adapt_enable_reg;
    logic               bypass_enable_reg;
    logic               error_from_ref_reg;

    logic               result_valid_reg;
    result_t            result_word_reg;

    ring_ctrl_t         ring_ctrl;
    dp_ctrl_t           dp_ctrl;
    logic               out_load;
    logic               out_free;
    logic               item_ready;

    logic signed [SAMPLE_W-1:0] x_q   [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] r_q   [TAP_COUNT];
    logic signed [TAP_W-1:0]    tap_q [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] x_feed;
    logic signed [SAMPLE_W-1:0] r_feed;
    logic signed [TAP_W-1:0]    tap_feed;
    logic signed [TAP_W-1:0]    tap_updated;
    logic signed [SAMPLE_W-1:0] filter_out;
    logic signed [SAMPLE_W-1:0] error_sample;

    // Config registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg      <= STEP_RESET;
            skip_count_reg     <= SKIP_RESET;
            decim_factor_reg   <= DECIM_RESET;
            adapt_enable_reg   <= 1'b1;
            bypass_enable_reg  <= 1'b0;
            error_from_ref_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                CFG_STEP_SIZE:      step_size_reg      <= cfg.payload.data;
                CFG_SKIP_COUNT:     skip_count_reg     <= cfg.payload.data;
                CFG_DECIM_FACTOR:   decim_factor_reg   <= cfg.payload.data[DECIM_W-1:0];
                CFG_ADAPT_ENABLE:   adapt_enable_reg   <= cfg.payload.data[0];
                CFG_BYPASS_ENABLE:  bypass_enable_reg  <= cfg.payload.data[0];
                CFG_ERROR_FROM_REF: error_from_ref_reg <= cfg.payload.data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Ring tail feed: new sample on a shift-in, head word on a rotation.
    assign x_feed   = ring_ctrl.load_sample ? item.payload.input_sample    : x_q[0];
    assign r_feed   = ring_ctrl.load_sample ? item.payload.filtered_sample : r_q[0];
    assign tap_feed = ring_ctrl.apply_update ? tap_updated : tap_q[0];

    for (genvar k = 0; k < TAP_COUNT; k++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] x_in;
        logic signed [SAMPLE_W-1:0] r_in;
        logic signed [TAP_W-1:0]    tap_in;

        if (k == TAP_COUNT - 1)
        begin : g_tail
            assign x_in   = x_feed;
            assign r_in   = r_feed;
            assign tap_in = tap_feed;
        end
        else
        begin : g_link
            assign x_in   = x_q[k+1];
            assign r_in   = r_q[k+1];
            assign tap_in = tap_q[k+1];
        end

        lmsaf_tap_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ring_ctrl),
            .x_in      (x_in),
            .r_in      (r_in),
            .tap_in    (tap_in),
            .tap_index (item.payload.tap_index),
            .tap_value (item.payload.tap_value),
            .x_q       (x_q[k]),
            .r_q       (r_q[k]),
            .tap_q     (tap_q[k])
        );
    end

    lmsaf_datapath #(
        .TAP_COUNT (TAP_COUNT)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctrl                 (dp_ctrl),
        .desired_sample       (item.payload.desired_sample),
        .input_sample         (item.payload.input_sample),
        .step_size            (step_size_reg),
        .error_from_reference (error_from_ref_reg),
        .tap_head             (tap_q[0]),
        .x_head               (x_q[0]),
        .r_head               (r_q[0]),
        .tap_updated          (tap_updated),
        .filter_out           (filter_out),
        .error_sample         (error_sample)
    );

    assign out_free = !result_valid_reg || result.ready;

    lmsaf_seq #(
        .TAP_COUNT (TAP_COUNT)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item.valid),
        .item_opcode   (item.payload.opcode),
        .skip_count    (skip_count_reg),
        .decim_factor  (decim_factor_reg),
        .adapt_enable  (adapt_enable_reg),
        .bypass_enable (bypass_enable_reg),
        .out_free      (out_free),
        .item_ready    (item_ready),
        .out_load      (out_load),
        .ring_ctrl     (ring_ctrl),
        .dp_ctrl       (dp_ctrl)
    );

    assign item.ready = item_ready;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_word_reg.filter_out   <= filter_out;
            result_word_reg.error_sample <= error_sample;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_word_reg;

endmodule

### rtl/core/lmsaf_checker.sv
// Port-level checks for the LMS adaptive FIR filter, bound to the top level.
// Depends on lmsaf_pkg and lms_adaptive_fir_filter_unit.
module lmsaf_checker import lmsaf_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic [OPCODE_W-1:0] item_opcode,
    input logic                result_valid,
    input logic                result_ready,
    input result_t             result_word
);

    logic item_take_ctl;

    assign item_take_ctl = item_valid && item_ready && (item_opcode != OP_SAMPLE);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_word))
        else $error("result word changed while stalled");

    a_ctl_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take_ctl |=> item_ready)
        else $error("tap write or clear did not finish in one cycle");

    a_ctl_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_take_ctl && !result_valid |=> !result_valid)
        else $error("tap write or clear produced a result word");

endmodule

bind lms_adaptive_fir_filter_unit lmsaf_checker u_lmsaf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_opcode  (item.payload.opcode),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_word  (result.payload)
);

### tb/lms_adaptive_fir_filter_unit_test.sv
// Testbench for the LMS adaptive FIR filter unit: directed and random words on the
// item and config channels, with a cycle-accurate-free predictor checking every result.
// Depends on lmsaf_pkg, lmsaf_if and the lms_adaptive_fir_filter_unit RTL.
module lms_adaptive_fir_filter_unit_test;
    import lmsaf_pkg::*;

    localparam int TAP_COUNT        = 32;
    localparam int SETTLE_CYCLES    = 100;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_ITEMS      = 130;
    localparam int LONG_DECIM_ITEMS = 150;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [15:0] step;
        logic [15:0] skip;
        logic [15:0] decim;
        logic [15:0] adapt;
        logic [15:0] bypass;
        logic [15:0] err_ref;
    } setting_t;

    logic clk = 1'b0;
    logic rst_n;

    lmsaf_item_if   item_bus ();
    lmsaf_result_if result_bus ();
    lmsaf_cfg_if    cfg_bus ();

    lms_adaptive_fir_filter_unit #(.TAP_COUNT(TAP_COUNT)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // filter state as predicted
    logic signed [SAMPLE_W-1:0] x_line [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] r_line [TAP_COUNT];
    logic signed [TAP_W-1:0]    tap_bank [TAP_COUNT];
    int unsigned                skip_ctr;
    int unsigned                decim_phase;
    logic [STEP_W-1:0]          step_reg;
    logic [SKIP_W-1:0]          skip_reg;
    logic [DECIM_W-1:0]         decim_reg;
    logic                       adapt_reg;
    logic                       bypass_reg;
    logic                       err_ref_reg;

    result_t expected_outputs [$];

    int  words_sent;
    int  results_checked;
    int  mismatches;
    int  settings_applied;
    int  stall_run;
    int  cycles;
    bit  steady;

    always #4 clk = ~clk;

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    task automatic compute_filter_response(input item_t it);
        longint  acc;
        longint  y;
        longint  e;
        longint  p;
        longint  delta;
        longint  mu;
        int      dec;
        bit      emit;
        result_t r;
        case (it.opcode)
            OP_WRITE_TAP:
            begin
                tap_bank[it.tap_index] = it.tap_value;
                return;
            end
            OP_CLEAR_TAPS:
            begin
                foreach (tap_bank[k])
                    tap_bank[k] = '0;
                return;
            end
            OP_SAMPLE:
            begin
            end
            default:
                return;
        endcase

        for (int k = 0; k < TAP_COUNT - 1; k++)
        begin
            x_line[k] = x_line[k + 1];
            r_line[k] = r_line[k + 1];
        end
        x_line[TAP_COUNT - 1] = it.input_sample;
        r_line[TAP_COUNT - 1] = it.filtered_sample;

        dec = (decim_reg == 0) ? 1 : (decim_reg > DECIM_MAX) ? int'(DECIM_MAX) : int'(decim_reg);
        emit = (decim_phase == 0);
        decim_phase = (decim_phase + 1 >= dec) ? 0 : decim_phase + 1;
        if (!emit)
            return;

        if (bypass_reg)
        begin
            r.filter_out   = it.input_sample;
            r.error_sample = '0;
            expected_outputs.push_back(r);
            return;
        end

        acc = 0;
        for (int k = 0; k < TAP_COUNT; k++)
            acc += longint'($signed(tap_bank[k])) * longint'($signed(x_line[k]));
        y = clamp((acc + (longint'(1) <<< 19)) >>> 20, SAMPLE_W);

        if (err_ref_reg)
            e = clamp(longint'($signed(it.desired_sample)) - y, SAMPLE_W);
        else
            e = longint'($signed(it.desired_sample));

        if (adapt_reg && (skip_reg == 0 || skip_ctr >= int'(skip_reg) + 1))
        begin
            skip_ctr = 0;
            mu = (step_reg > STEP_MAX) ? longint'(STEP_MAX) : longint'(step_reg);
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                p = mu * e * longint'($signed(r_line[k]));
                delta = (p + (longint'(1) <<< 24)) >>> 25;
                tap_bank[k] = TAP_W'(clamp(longint'($signed(tap_bank[k])) + delta, TAP_W));
            end
        end
        else if (skip_ctr < SKIP_CNT_MAX)
        begin
            skip_ctr++;
        end

        r.filter_out   = y[SAMPLE_W-1:0];
        r.error_sample = e[SAMPLE_W-1:0];
        expected_outputs.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        do
            @(posedge clk);
        while (!item_bus.ready);
        compute_filter_response(it);
        words_sent++;
    endtask

    task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
        cfg_word_t w;
        w.index = idx;
        w.data  = data;
        cfg_bus.valid   <= 1'b1;
        cfg_bus.payload <= w;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_STEP_SIZE:      step_reg    = data[STEP_W-1:0];
            CFG_SKIP_COUNT:     skip_reg    = data[SKIP_W-1:0];
            CFG_DECIM_FACTOR:   decim_reg   = data[DECIM_W-1:0];
            CFG_ADAPT_ENABLE:   adapt_reg   = data[0];
            CFG_BYPASS_ENABLE:  bypass_reg  = data[0];
            CFG_ERROR_FROM_REF: err_ref_reg = data[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_setting(input setting_t s);
        write_register(CFG_STEP_SIZE, s.step);
        write_register(CFG_SKIP_COUNT, s.skip);
        write_register(CFG_DECIM_FACTOR, s.decim);
        write_register(CFG_ADAPT_ENABLE, s.adapt);
        write_register(CFG_BYPASS_ENABLE, s.bypass);
        write_register(CFG_ERROR_FROM_REF, s.err_ref);
        cfg_bus.valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic setting_t make_setting(input int step, input int skip, input int decim,
                                              input int adapt, input int bypass,
                                              input int err_ref);
        setting_t s;
        s.step    = 16'(step);
        s.skip    = 16'(skip);
        s.decim   = 16'(decim);
        s.adapt   = 16'(adapt);
        s.bypass  = 16'(bypass);
        s.err_ref = 16'(err_ref);
        return s;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if (r < 55)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(0, 8191) - 4096);
    endfunction

    function automatic logic signed [TAP_W-1:0] rand_tap_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        if (r < 50)
            return TAP_W'($urandom);
        return TAP_W'($urandom_range(0, 131071) - 65536);
    endfunction

    function automatic item_t make_word(input logic [OPCODE_W-1:0] op);
        item_t it;
        it.opcode          = op;
        it.desired_sample  = rand_sample();
        it.input_sample    = rand_sample();
        it.filtered_sample = $urandom_range(0, 1) ? it.input_sample : rand_sample();
        it.tap_index       = TAP_INDEX_W'($urandom);
        it.tap_value       = rand_tap_value();
        return it;
    endfunction

    function automatic item_t make_sample(input logic signed [SAMPLE_W-1:0] d,
                                          input logic signed [SAMPLE_W-1:0] x,
                                          input logic signed [SAMPLE_W-1:0] f);
        item_t it;
        it = make_word(OP_SAMPLE);
        it.desired_sample  = d;
        it.input_sample    = x;
        it.filtered_sample = f;
        return it;
    endfunction

    function automatic item_t make_tap_write(input int idx, input logic signed [TAP_W-1:0] v);
        item_t it;
        it = make_word(OP_WRITE_TAP);
        it.tap_index = TAP_INDEX_W'(idx);
        it.tap_value = v;
        return it;
    endfunction

    function automatic setting_t random_setting();
        setting_t s;
        int       pick;
        int       decim;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       s.step = 0;
            1:       s.step = 1;
            2:       s.step = STEP_MAX;
            3:       s.step = 16'($urandom_range(32769, 65535));
            4, 5:    s.step = STEP_RESET;
            default: s.step = 16'($urandom_range(1, 32768));
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 5)
            s.skip = 0;
        else if (pick < 8)
            s.skip = 16'($urandom_range(1, 5));
        else if (pick == 8)
            s.skip = 16'hFFFF;
        else
            s.skip = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            decim = 1;
        else if (pick < 8)
            decim = $urandom_range(2, 4);
        else if (pick == 8)
            decim = $urandom_range(5, 16);
        else
            decim = 0;
        s.decim   = {7'($urandom), 9'(decim)};
        s.adapt   = {15'($urandom), 1'($urandom_range(0, 4) != 0)};
        s.bypass  = {15'($urandom), 1'($urandom_range(0, 6) == 0)};
        s.err_ref = {15'($urandom), 1'($urandom_range(0, 3) != 0)};
        return s;
    endfunction

    function automatic item_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84)
            return make_word(OP_SAMPLE);
        if (r < 93)
            return make_word(OP_WRITE_TAP);
        if (r < 95)
            return make_word(OP_CLEAR_TAPS);
        return make_word(OP_UNUSED);
    endfunction

    task automatic test_reset_defaults();
        send_item(make_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
        send_item(make_sample(16'sh8000, 16'sh8000, 16'sh8000));
        send_item(make_sample(1000, -2000, 500));
        settle();
    endtask

    task automatic test_tap_access();
        apply_setting(make_setting(STEP_RESET, 0, 1, 1, 0, 1));
        send_item(make_tap_write(0, 24'sh7FFFFF));
        send_item(make_tap_write(31, 24'sh800000));
        send_item(make_sample(0, 16'sh7FFF, 100));
        send_item(make_word(OP_UNUSED));
        send_item(make_word(OP_CLEAR_TAPS));
        send_item(make_sample(5, 16'sh8000, -1));
        settle();
    endtask

    task automatic test_saturation();
        apply_setting(make_setting(16'hFFFF, 0, 1, 1, 0, 1));
        send_item(make_tap_write(31, 24'sh7FFFFF));
        send_item(make_tap_write(30, 24'sh7FFFFF));
        send_item(make_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF));
        send_item(make_sample(16'sh7FFF, 16'sh8000, 16'sh8000));
        send_item(make_sample(16'sh8000, 16'sh7FFF, 16'sh8000));
        settle();
    endtask

    task automatic test_special_settings();
        // decimation zero acts as one
        apply_setting(make_setting(STEP_RESET, 0, 0, 1, 0, 1));
        send_item(make_sample(300, 200, 100));
        settle();
        // zero step, desired taken as the error
        apply_setting(make_setting(0, 0, 1, 1, 0, 0));
        send_item(make_sample(16'sh8000, 1234, 4321));
        send_item(make_sample(16'sh7FFF, -1234, 77));
        settle();
        // frozen taps still advance the skip counter
        apply_setting(make_setting(STEP_RESET, 2, 1, 0, 0, 1));
        send_item(make_sample(2000, 3000, 3000));
        settle();
        apply_setting(make_setting(STEP_RESET, 2, 1, 1, 0, 1));
        send_item(make_sample(-2000, 3000, 3000));
        send_item(make_sample(2000, -3000, -3000));
        send_item(make_sample(4000, 500, 500));
        settle();
        // bypass with decimation
        apply_setting(make_setting(STEP_RESET, 0, 3, 1, 1, 1));
        send_item(make_sample(10, 16'sh7FFF, 1));
        send_item(make_sample(20, 16'sh8000, 2));
        send_item(make_sample(30, 16'sh8000, 3));
        settle();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       apply_setting(make_setting(1, 0, 1, 1, 0, 1));
                1:       apply_setting(make_setting(STEP_MAX, 16'hFFFF, 1, 1, 0, 1));
                default: apply_setting(random_setting());
            endcase
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
            settle();
            steady = 1'b0;
        end
    endtask

    task automatic test_long_decimation();
        apply_setting(make_setting(STEP_RESET, 0, 16'hFF00 | DECIM_MAX, 1, 0, 1));
        for (int n = 0; n < LONG_DECIM_ITEMS; n++)
            send_item(make_word(OP_SAMPLE));
        settle();
        // all nine bits set: clamps to the largest factor
        apply_setting(make_setting(STEP_RESET, 0, 16'h01FF, 1, 0, 1));
        for (int n = 0; n < LONG_DECIM_ITEMS; n++)
            send_item(make_word(OP_SAMPLE));
        settle();
    endtask

    always @(posedge clk)
    begin : ready_gen
        int pick;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
        end
        else if (steady)
        begin
            result_bus.ready <= 1'b1;
            stall_run = $urandom_range(8, 40);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                result_bus.ready <= 1'b1;
                stall_run = $urandom_range(0, 8);
            end
            else if (pick < 93)
            begin
                result_bus.ready <= 1'b0;
                stall_run = $urandom_range(0, 3);
            end
            else
            begin
                result_bus.ready <= 1'b0;
                stall_run = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got filter_out %0d error_sample %0d",
                         $time, $signed(result_bus.payload.filter_out),
                         $signed(result_bus.payload.error_sample));
                mismatches++;
            end
            else
            begin
                want = expected_outputs.pop_front();
                results_checked++;
                if (result_bus.payload.filter_out !== want.filter_out)
                begin
                    $display("%0t: filter_out expected %0d got %0d", $time,
                             $signed(want.filter_out), $signed(result_bus.payload.filter_out));
                    mismatches++;
                end
                if (result_bus.payload.error_sample !== want.error_sample)
                begin
                    $display("%0t: error_sample expected %0d got %0d", $time,
                             $signed(want.error_sample), $signed(result_bus.payload.error_sample));
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 expected_outputs.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.payload = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.payload  = '0;
        steady           = 1'b0;
        words_sent       = 0;
        results_checked  = 0;
        mismatches       = 0;
        settings_applied = 0;
        foreach (x_line[k])
        begin
            x_line[k]   = '0;
            r_line[k]   = '0;
            tap_bank[k] = '0;
        end
        skip_ctr    = 0;
        decim_phase = 0;
        step_reg    = STEP_RESET;
        skip_reg    = SKIP_RESET;
        decim_reg   = DECIM_RESET;
        adapt_reg   = 1'b1;
        bypass_reg  = 1'b0;
        err_ref_reg = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_tap_access();
        test_saturation();
        test_special_settings();
        test_random_traffic();
        test_long_decimation();

        $display("%0d item words sent under %0d register settings", words_sent, settings_applied);
        $display("%0d results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
